### rtl/core/tre_pkg.sv
package tre_pkg;

    // Message framing
    localparam int MSG_LEN = 28;
    localparam int IDX_W   = $clog2(MSG_LEN);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MSG_LEN - 1);

    localparam logic [7:0]  ID_OWNSHIP = 8'd10;
    localparam logic [7:0]  ID_TRAFFIC = 8'd20;
    localparam logic [7:0]  ALERT_BIT  = 8'h10;
    localparam logic [11:0] SPEED_MAX  = 12'hFFE;

    // Position: floor(|x|*32/45) = (|x| * ceil(2^35/45)) >> 30, exact for |x| < 2^24
    localparam int          POS_SHIFT = 30;
    localparam logic [29:0] RECIP_45  = 30'd763549742;

    // Altitude: floor((ft+1012)/25); bias by two 4096-code wraps keeps it positive
    localparam int          ALT_SHIFT = 24;
    localparam logic [18:0] ALT_BIAS  = 19'd205812;
    localparam logic [19:0] RECIP_25  = 20'd671089;

    // Track: floor((hdg+45)/90), exact for values below 2^16
    localparam int          TRK_SHIFT = 23;
    localparam logic [15:0] TRK_BIAS  = 16'd45;
    localparam logic [16:0] RECIP_90  = 17'd93207;

    // Raw report as taken at the input
    typedef struct packed {
        logic [5:0]         header_flags;
        logic [23:0]        target_address;
        logic signed [23:0] lat_q16;
        logic signed [24:0] lon_q16;
        logic signed [17:0] altitude_ft;
        logic [7:0]         indicator_bits;
        logic [7:0]         nav_categories;
        logic [11:0]        ground_speed;
        logic signed [17:0] vertical_fpm;
        logic [14:0]        heading_q6;
        logic [7:0]         emitter_class;
        logic [63:0]        call_sign;
    } t_report;

    // Magnitudes and biased operands ready for the reciprocal multipliers
    typedef struct packed {
        logic [5:0]  hdr;
        logic [23:0] addr;
        logic        lat_neg;
        logic [23:0] lat_mag;
        logic        lon_neg;
        logic [24:0] lon_mag;
        logic [18:0] alt_u;
        logic [7:0]  ind;
        logic [7:0]  nav;
        logic [11:0] spd;
        logic [11:0] vv;
        logic [15:0] trk_n;
        logic [7:0]  emit;
        logic [63:0] cs;
    } t_pre;

    // Converted fields, positions still as sign and magnitude
    typedef struct packed {
        logic [5:0]  hdr;
        logic [23:0] addr;
        logic        lat_neg;
        logic [23:0] lat_q;
        logic        lon_neg;
        logic [23:0] lon_q;
        logic [11:0] alt;
        logic [7:0]  ind;
        logic [7:0]  nav;
        logic [11:0] spd;
        logic [11:0] vv;
        logic [7:0]  trk;
        logic [7:0]  emit;
        logic [63:0] cs;
    } t_prod;

endpackage

### rtl/core/tre_convert.sv
module tre_convert (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tre_pkg::t_report i_report,
    output logic             o_valid,
    input  logic             i_ready,
    output tre_pkg::t_prod   o_prod
);
    import tre_pkg::*;

    logic        r_pre_valid;
    t_pre        r_pre;
    t_pre        n_pre;
    logic        r_prod_valid;
    t_prod       r_prod;
    t_prod       n_prod;
    logic        prod_free;
    logic        pre_free;
    logic [17:0] fpm_biased;
    logic [53:0] lat_prod;
    logic [54:0] lon_prod;
    logic [38:0] alt_prod;
    logic [32:0] trk_prod;

    // Stage flow: a stage loads when empty or when its content moves on
    assign prod_free = !r_prod_valid || i_ready;
    assign pre_free  = !r_pre_valid || prod_free;
    assign o_ready   = pre_free;
    assign o_valid   = r_prod_valid;
    assign o_prod    = r_prod;

    // First stage: magnitudes, offsets, saturation, vertical rate
    always_comb begin
        fpm_biased = $unsigned(i_report.vertical_fpm)
                     + {12'b0, {6{i_report.vertical_fpm[17]}}};

        n_pre.hdr     = i_report.header_flags;
        n_pre.addr    = i_report.target_address;
        n_pre.lat_neg = i_report.lat_q16[23];
        n_pre.lat_mag = i_report.lat_q16[23] ? (~$unsigned(i_report.lat_q16) + 24'd1)
                                             : $unsigned(i_report.lat_q16);
        n_pre.lon_neg = i_report.lon_q16[24];
        n_pre.lon_mag = i_report.lon_q16[24] ? (~$unsigned(i_report.lon_q16) + 25'd1)
                                             : $unsigned(i_report.lon_q16);
        // wraps modulo 2^19 to a positive value
        n_pre.alt_u   = {i_report.altitude_ft[17], $unsigned(i_report.altitude_ft)}
                        + ALT_BIAS;
        n_pre.ind     = i_report.indicator_bits;
        n_pre.nav     = i_report.nav_categories;
        n_pre.spd     = (i_report.ground_speed >= SPEED_MAX) ? SPEED_MAX
                                                             : i_report.ground_speed;
        // truncation toward zero: add 63 before the shift when negative
        n_pre.vv      = fpm_biased[17:6];
        n_pre.trk_n   = {1'b0, i_report.heading_q6} + TRK_BIAS;
        n_pre.emit    = i_report.emitter_class;
        n_pre.cs      = i_report.call_sign;
    end

    // Second stage: reciprocal multiplications
    always_comb begin
        lat_prod = 54'(r_pre.lat_mag) * 54'(RECIP_45);
        lon_prod = 55'(r_pre.lon_mag) * 55'(RECIP_45);
        alt_prod = 39'(r_pre.alt_u) * 39'(RECIP_25);
        trk_prod = 33'(r_pre.trk_n) * 33'(RECIP_90);

        n_prod.hdr     = r_pre.hdr;
        n_prod.addr    = r_pre.addr;
        n_prod.lat_neg = r_pre.lat_neg;
        n_prod.lat_q   = lat_prod[POS_SHIFT +: 24];
        n_prod.lon_neg = r_pre.lon_neg;
        n_prod.lon_q   = lon_prod[POS_SHIFT +: 24];
        n_prod.alt     = alt_prod[ALT_SHIFT +: 12];
        n_prod.ind     = r_pre.ind;
        n_prod.nav     = r_pre.nav;
        n_prod.spd     = r_pre.spd;
        n_prod.vv      = r_pre.vv;
        n_prod.trk     = trk_prod[TRK_SHIFT +: 8];
        n_prod.emit    = r_pre.emit;
        n_prod.cs      = r_pre.cs;
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid  <= 1'b0;
            r_prod_valid <= 1'b0;
        end else begin
            if (pre_free) begin
                r_pre_valid <= i_valid;
            end
            if (prod_free) begin
                r_prod_valid <= r_pre_valid;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (pre_free && i_valid) begin
            r_pre <= n_pre;
        end
        if (prod_free && r_pre_valid) begin
            r_prod <= n_prod;
        end
    end

endmodule

### rtl/core/traffic_report_encoder_top.sv
// The first message byte is strobed after the start transfer has passed the input register,
// the pre and product conversion stages and the message register. The 28 bytes follow on
// consecutive cycles, byte 27 flagged by o_last_byte. The byte-wide result port limits
// the report rate; the next report is taken while the current message is being sent.
// The receiver cannot stall: each byte is valid for exactly one cycle.
// Reset (synchronous, active low) empties the pipeline and drops any partial message.
module traffic_report_encoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [5:0]         i_header_flags,
    input  logic [23:0]        i_target_address,
    input  logic signed [23:0] i_lat_q16,
    input  logic signed [24:0] i_lon_q16,
    input  logic signed [17:0] i_altitude_ft,
    input  logic [7:0]         i_indicator_bits,
    input  logic [7:0]         i_nav_categories,
    input  logic [11:0]        i_ground_speed,
    input  logic signed [17:0] i_vertical_fpm,
    input  logic [14:0]        i_heading_q6,
    input  logic [7:0]         i_emitter_class,
    input  logic [63:0]        i_call_sign,
    output logic               o_byte_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_last_byte
);
    import tre_pkg::*;

    logic             r_in_valid;
    t_report          r_in;
    logic             in_free;
    logic             conv_ready;
    logic             prod_valid;
    t_prod            prod;
    logic             msg_free;
    logic             msg_load;
    logic             r_msg_valid;
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_msg [MSG_LEN];
    logic [7:0]       n_msg [MSG_LEN];
    logic [23:0]      lat_v;
    logic [23:0]      lon_v;

    // Input register
    assign in_free = !r_in_valid || conv_ready;
    assign busy    = !in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && start) begin
            r_in.header_flags   <= i_header_flags;
            r_in.target_address <= i_target_address;
            r_in.lat_q16        <= i_lat_q16;
            r_in.lon_q16        <= i_lon_q16;
            r_in.altitude_ft    <= i_altitude_ft;
            r_in.indicator_bits <= i_indicator_bits;
            r_in.nav_categories <= i_nav_categories;
            r_in.ground_speed   <= i_ground_speed;
            r_in.vertical_fpm   <= i_vertical_fpm;
            r_in.heading_q6     <= i_heading_q6;
            r_in.emitter_class  <= i_emitter_class;
            r_in.call_sign      <= i_call_sign;
        end
    end

    // Field conversion
    tre_convert u_convert (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .o_ready  (conv_ready),
        .i_report (r_in),
        .o_valid  (prod_valid),
        .i_ready  (msg_free),
        .o_prod   (prod)
    );

    // Message assembly: apply position signs and lay out the bytes
    always_comb begin
        lat_v = prod.lat_neg ? (~prod.lat_q + 24'd1) : prod.lat_q;
        lon_v = prod.lon_neg ? (~prod.lon_q + 24'd1) : prod.lon_q;

        n_msg[0]  = prod.hdr[5] ? ID_OWNSHIP : ID_TRAFFIC;
        n_msg[1]  = (prod.hdr[4] ? ALERT_BIT : 8'h00) | {4'h0, prod.hdr[3:0]};
        n_msg[2]  = prod.addr[23:16];
        n_msg[3]  = prod.addr[15:8];
        n_msg[4]  = prod.addr[7:0];
        n_msg[5]  = lat_v[23:16];
        n_msg[6]  = lat_v[15:8];
        n_msg[7]  = lat_v[7:0];
        n_msg[8]  = lon_v[23:16];
        n_msg[9]  = lon_v[15:8];
        n_msg[10] = lon_v[7:0];
        n_msg[11] = prod.alt[11:4];
        n_msg[12] = {prod.alt[3:0], prod.ind[3:0]};
        n_msg[13] = prod.nav;
        n_msg[14] = prod.spd[11:4];
        n_msg[15] = {prod.spd[3:0], prod.vv[11:8]};
        n_msg[16] = prod.vv[7:0];
        n_msg[17] = prod.trk;
        n_msg[18] = prod.emit;
        for (int i = 0; i < 8; i++) begin
            n_msg[19 + i] = prod.cs[63 - 8 * i -: 8];
        end
        n_msg[27] = {prod.ind[7:4], 4'h0};
    end

    // Byte serialiser: a new message loads as the last byte goes out
    assign msg_free = !r_msg_valid || (r_idx == IDX_LAST);
    assign msg_load = prod_valid && msg_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_valid <= 1'b0;
            r_idx       <= '0;
        end else if (msg_load) begin
            r_msg_valid <= 1'b1;
            r_idx       <= '0;
        end else if (r_msg_valid) begin
            if (r_idx == IDX_LAST) begin
                r_msg_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (msg_load) begin
            r_msg <= n_msg;
        end else if (r_msg_valid) begin
            for (int i = 0; i < MSG_LEN - 1; i++) begin
                r_msg[i] <= r_msg[i + 1];
            end
        end
    end

    // Result port
    assign o_byte_valid = r_msg_valid;
    assign o_out_byte   = r_msg[0];
    assign o_last_byte  = r_msg_valid && (r_idx == IDX_LAST);

endmodule
